/* rtl/core/rtcfc_pkg.sv */
// Package for the RTC time/date format converter.
// Holds command codes, register indexes, payload structs and BCD/calendar helpers.
// No dependencies.
package rtcfc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_BINARY_MODE = 1'b0;
   localparam logic REG_HOUR24_MODE = 1'b1;

   localparam logic [7:0]  PM_FLAG      = 8'h80;
   localparam logic [7:0]  HOUR_MAX     = 8'd23;
   localparam logic [7:0]  MINSEC_MAX   = 8'd59;
   localparam logic [6:0]  HOURS_HALF   = 7'd12;
   localparam logic [7:0]  CENTURY_LO   = 8'd19;
   localparam logic [7:0]  CENTURY_HI   = 8'd99;
   localparam logic [6:0]  CENTURY_DEF  = 7'd20;
   localparam logic [15:0] YEAR_MIN     = 16'd1980;
   localparam logic [15:0] YEAR_MAX     = 16'd2099;
   localparam logic [15:0] YEAR_2000    = 16'd2000;
   localparam logic [15:0] YEAR_1900    = 16'd1900;

   typedef enum logic [1:0] {
      CMD_DECODE_TIME = 2'd0,
      CMD_DECODE_DATE = 2'd1,
      CMD_ENCODE_TIME = 2'd2,
      CMD_ENCODE_DATE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic binary;
      logic hour24;
   } mode_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  first_field;
      logic [7:0]  second_field;
      logic [7:0]  third_field;
      logic [7:0]  century_field;
      logic [15:0] year_field;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  first_out;
      logic [7:0]  second_out;
      logic [7:0]  third_out;
      logic [7:0]  century_out;
      logic [15:0] year_out;
   } rsp_type;

   // high digit times ten plus low digit; bad digits pass through unchecked
   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      logic [7:0] hi8;
      logic [7:0] hi2;
      hi8 = {1'b0, b[7:4], 3'b000};
      hi2 = {3'b000, b[7:4], 1'b0};
      return hi8 + hi2 + {4'b0000, b[3:0]};
   endfunction

   // valid for v up to 99: tens by reciprocal multiply
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens10;
      logic [6:0]  ones;
      prod   = {8'b0, v} * 15'd205;
      tens   = prod[14:11];
      tens10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
      ones   = v - tens10;
      return {tens, ones[3:0]};
   endfunction

   function automatic logic [4:0] month_last_day(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd2: begin
            d = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            d = 5'd30;
         end
         default: begin
            d = 5'd31;
         end
      endcase
      return d;
   endfunction

endpackage

/* rtl/core/rtcfc_csr.sv */
// Configuration registers of the RTC format converter: binary and 24-hour modes.
// APB-style write/read port. Depends on rtcfc_pkg.
module rtcfc_csr import rtcfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output mode_type              mode
);

   mode_type mode_ff;
   mode_type mode_in;
   logic     wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      mode_in = mode_ff;
      if (wr_en) begin
         if (paddr[2] == REG_BINARY_MODE) begin
            mode_in.binary = pwdata[0];
         end else begin
            mode_in.hour24 = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_HOUR24_MODE) begin
         prdata[0] = mode_ff.hour24;
      end else begin
         prdata[0] = mode_ff.binary;
      end
   end

   assign mode = mode_ff;

endmodule

/* rtl/core/rtcfc_conv.sv */
// Conversion datapath: decode/encode of time and date register bytes, range checks.
// Purely combinational, sits between the request and result registers. Depends on rtcfc_pkg.
module rtcfc_conv import rtcfc_pkg::*; (
   input  mode_type mode,
   input  req_type  req,
   output rsp_type  rsp
);

   // decode time
   logic [7:0] dt_s;
   logic [7:0] dt_m;
   logic [7:0] dt_hbcd;
   logic [7:0] dt_h8;
   logic [6:0] dt_h7;
   logic [6:0] dt_h;
   logic       dt_ok;

   // decode date
   logic [7:0]  dd_d;
   logic [7:0]  dd_m;
   logic [7:0]  dd_y;
   logic [7:0]  dd_c;
   logic [6:0]  dd_csel;
   logic [13:0] dd_full;
   logic [1:0]  dd_yq;
   logic [7:0]  dd_yr;
   logic [7:0]  dd_cy;
   logic        dd_leap;
   logic        dd_mok;
   logic        dd_ok;

   // encode time
   logic       et_ok;
   logic       et_pm;
   logic [6:0] et_h12;
   logic [6:0] et_hval;
   logic       et_hpm;
   logic [7:0] et_s;
   logic [7:0] et_m;
   logic [7:0] et_h;

   // encode date
   logic        ed_mok;
   logic        ed_ok;
   logic        ed_lo;
   logic [15:0] ed_ydiff;
   logic [6:0]  ed_y;
   logic [6:0]  ed_c;
   logic [7:0]  ed_d_o;
   logic [7:0]  ed_m_o;
   logic [7:0]  ed_y_o;
   logic [7:0]  ed_c_o;

   always_comb begin
      dt_s    = mode.binary ? req.first_field  : from_bcd(req.first_field);
      dt_m    = mode.binary ? req.second_field : from_bcd(req.second_field);
      dt_hbcd = from_bcd({1'b0, req.third_field[6:0]});
      dt_h8   = mode.binary ? req.third_field : {req.third_field[7], dt_hbcd[6:0]};
      dt_h7   = dt_h8[6:0];
      dt_h    = dt_h7;
      if (!mode.hour24) begin
         if (dt_h8[7] && (dt_h7 < HOURS_HALF)) begin
            dt_h = dt_h7 + HOURS_HALF;
         end else if (!dt_h8[7] && (dt_h7 == HOURS_HALF)) begin
            dt_h = '0;
         end
      end
      dt_ok = ({1'b0, dt_h} <= HOUR_MAX) && (dt_m <= MINSEC_MAX) && (dt_s <= MINSEC_MAX);
   end

   always_comb begin
      dd_d    = mode.binary ? req.first_field   : from_bcd(req.first_field);
      dd_m    = mode.binary ? req.second_field  : from_bcd(req.second_field);
      dd_y    = mode.binary ? req.third_field   : from_bcd(req.third_field);
      dd_c    = mode.binary ? req.century_field : from_bcd(req.century_field);
      dd_csel = ((dd_c >= CENTURY_LO) && (dd_c <= CENTURY_HI)) ? dd_c[6:0] : CENTURY_DEF;
      dd_full = {7'b0, dd_csel} * 14'd100 + {6'b0, dd_y};
      if (dd_y >= 8'd200) begin
         dd_yq = 2'd2;
         dd_yr = dd_y - 8'd200;
      end else if (dd_y >= 8'd100) begin
         dd_yq = 2'd1;
         dd_yr = dd_y - 8'd100;
      end else begin
         dd_yq = 2'd0;
         dd_yr = dd_y;
      end
      dd_cy   = {1'b0, dd_csel} + {6'b0, dd_yq};
      dd_leap = (dd_yr == 8'd0) ? (dd_cy[1:0] == 2'b00) : (dd_y[1:0] == 2'b00);
      dd_mok  = (dd_m >= 8'd1) && (dd_m <= 8'd12);
      dd_ok   = dd_mok && (dd_d >= 8'd1) &&
                (dd_d <= {3'b000, month_last_day(dd_m[3:0], dd_leap)});
   end

   always_comb begin
      et_ok   = (req.third_field <= HOUR_MAX) && (req.second_field <= MINSEC_MAX) &&
                (req.first_field <= MINSEC_MAX);
      et_pm   = req.third_field[6:0] >= HOURS_HALF;
      et_h12  = et_pm ? (req.third_field[6:0] - HOURS_HALF) : req.third_field[6:0];
      if (et_h12 == 7'd0) begin
         et_h12 = HOURS_HALF;
      end
      et_hval = mode.hour24 ? req.third_field[6:0] : et_h12;
      et_hpm  = !mode.hour24 && et_pm;
      if (mode.binary) begin
         et_s = req.first_field;
         et_m = req.second_field;
         et_h = {et_hpm, et_hval};
      end else begin
         et_s = to_bcd(req.first_field[6:0]);
         et_m = to_bcd(req.second_field[6:0]);
         et_h = to_bcd(et_hval) | (et_hpm ? PM_FLAG : 8'h00);
      end
   end

   always_comb begin
      ed_mok   = (req.second_field >= 8'd1) && (req.second_field <= 8'd12);
      ed_ok    = (req.year_field >= YEAR_MIN) && (req.year_field <= YEAR_MAX) && ed_mok &&
                 (req.first_field >= 8'd1) &&
                 (req.first_field <=
                  {3'b000, month_last_day(req.second_field[3:0], req.year_field[1:0] == 2'b00)});
      ed_lo    = req.year_field < YEAR_2000;
      ed_ydiff = req.year_field - (ed_lo ? YEAR_1900 : YEAR_2000);
      ed_y     = ed_ydiff[6:0];
      ed_c     = ed_lo ? 7'd19 : 7'd20;
      if (mode.binary) begin
         ed_d_o = req.first_field;
         ed_m_o = req.second_field;
         ed_y_o = {1'b0, ed_y};
         ed_c_o = {1'b0, ed_c};
      end else begin
         ed_d_o = to_bcd(req.first_field[6:0]);
         ed_m_o = to_bcd(req.second_field[6:0]);
         ed_y_o = to_bcd(ed_y);
         ed_c_o = to_bcd(ed_c);
      end
   end

   always_comb begin
      rsp = '0;
      case (req.cmd)
         CMD_DECODE_TIME: begin
            if (dt_ok) begin
               rsp.ok         = 1'b1;
               rsp.first_out  = dt_s;
               rsp.second_out = dt_m;
               rsp.third_out  = {1'b0, dt_h};
            end
         end
         CMD_DECODE_DATE: begin
            if (dd_ok) begin
               rsp.ok         = 1'b1;
               rsp.first_out  = dd_d;
               rsp.second_out = dd_m;
               rsp.year_out   = {2'b00, dd_full};
            end
         end
         CMD_ENCODE_TIME: begin
            if (et_ok) begin
               rsp.ok         = 1'b1;
               rsp.first_out  = et_s;
               rsp.second_out = et_m;
               rsp.third_out  = et_h;
            end
         end
         CMD_ENCODE_DATE: begin
            if (ed_ok) begin
               rsp.ok          = 1'b1;
               rsp.first_out   = ed_d_o;
               rsp.second_out  = ed_m_o;
               rsp.third_out   = ed_y_o;
               rsp.century_out = ed_c_o;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

/* rtl/core/rtc_time_date_format_converter_top.sv */
// Channel   | Signals                                   | Transfer
// ----------+-------------------------------------------+----------------------------------
// request   | start, busy, req_cmd, req_*_field         | start high and busy low at edge
// response  | rsp_strobe, rsp_ok, rsp_*_out             | one cycle per strobe, no stall
// csr       | psel, penable, pwrite, paddr, pwdata, ... | write on psel&penable&pwrite&pready
//
// One transaction per cycle; an accepted request passes through the request register, then the
// conversion logic into the result register, and rsp_strobe rises while the result register
// holds that result. busy is never asserted.
// Synchronous active-high reset clears the valid flags and modes.
// Top level of the RTC format converter. Depends on rtcfc_pkg, rtcfc_csr, rtcfc_conv.
module rtc_time_date_format_converter_top import rtcfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [7:0]            req_first_field,
   input  logic [7:0]            req_second_field,
   input  logic [7:0]            req_third_field,
   input  logic [7:0]            req_century_field,
   input  logic [15:0]           req_year_field,
   output logic                  rsp_strobe,
   output logic                  rsp_ok,
   output logic [7:0]            rsp_first_out,
   output logic [7:0]            rsp_second_out,
   output logic [7:0]            rsp_third_out,
   output logic [7:0]            rsp_century_out,
   output logic [15:0]           rsp_year_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   mode_type mode;
   req_type  req_in;
   req_type  req_ff;
   logic     req_valid_in;
   logic     req_valid_ff;
   rsp_type  conv_rsp;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;

   assign busy = 1'b0;

   rtcfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .mode    (mode)
   );

   always_comb begin
      req_valid_in         = start & ~busy;
      req_in.cmd           = cmd_type'(req_cmd);
      req_in.first_field   = req_first_field;
      req_in.second_field  = req_second_field;
      req_in.third_field   = req_third_field;
      req_in.century_field = req_century_field;
      req_in.year_field    = req_year_field;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         rsp_ff <= conv_rsp;
      end
   end

   rtcfc_conv u_conv (
      .mode (mode),
      .req  (req_ff),
      .rsp  (conv_rsp)
   );

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_first_out   = rsp_ff.first_out;
   assign rsp_second_out  = rsp_ff.second_out;
   assign rsp_third_out   = rsp_ff.third_out;
   assign rsp_century_out = rsp_ff.century_out;
   assign rsp_year_out    = rsp_ff.year_out;

endmodule

/* rtl/core/rtcfc_checker.sv */
// Port-level checker for the RTC format converter, bound to the top level.
// Depends on rtcfc_pkg and rtc_time_date_format_converter_top.
module rtcfc_checker import rtcfc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [1:0]            req_cmd,
   input logic                  rsp_strobe,
   input logic                  rsp_ok,
   input logic [7:0]            rsp_first_out,
   input logic [7:0]            rsp_second_out,
   input logic [7:0]            rsp_third_out,
   input logic [7:0]            rsp_century_out,
   input logic [15:0]           rsp_year_out
);

   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted transaction");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_first_out == 8'd0 && rsp_second_out == 8'd0 &&
         rsp_third_out == 8'd0 && rsp_century_out == 8'd0 && rsp_year_out == 16'd0))
      else $error("failed conversion carries nonzero fields");

   a_time_no_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_cmd, 2) == CMD_DECODE_TIME ||
                      $past(req_cmd, 2) == CMD_ENCODE_TIME))
      |-> (rsp_century_out == 8'd0 && rsp_year_out == 16'd0))
      else $error("time result carries date fields");

endmodule

bind rtc_time_date_format_converter_top rtcfc_checker u_checker (.*);
